### sv/fxr_pkg.sv
// ---------------------------------------------------------------------------
// fxr_pkg: shared constants and helpers for the radix digit converter
// Holds field widths, ASCII codes, the base limits and the digit mapping.
// ---------------------------------------------------------------------------
`default_nettype none

package fxr_pkg;

  // Fixed field widths of the streaming payloads.
  localparam int VALUE_W = 40;
  localparam int CHAR_W  = 7;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_STEPS = 4;

  // Base register limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // ASCII codes.
  localparam logic [CHAR_W-1:0]  ASCII_DIGIT_BASE  = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
  localparam logic [CHAR_W-1:0]  ASCII_POINT       = 7'd46;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS    = 6'd10;

  // Clamp a programmed base into the supported range.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to its character: 0-9 to '0'-'9', 10-35 to 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DECIMAL_DIGITS) begin
      res = ASCII_DIGIT_BASE + CHAR_W'(d);
    end else begin
      res = ASCII_LETTER_BASE + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/fxr_div.sv
// ---------------------------------------------------------------------------
// fxr_div: iterative divider of the integer part by the number base
// Restoring division resolving a few quotient bits per cycle; pulses done
// when quotient and remainder are ready.
// ---------------------------------------------------------------------------
`default_nettype none

module fxr_div #(
  parameter int INT_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [INT_BITS-1:0]         dividend,
  input  wire logic [fxr_pkg::RADIX_W-1:0] divisor,
  output logic                             done,
  output logic [INT_BITS-1:0]              quotient,
  output logic [fxr_pkg::DIGIT_W-1:0]      remainder
);

  localparam int STEPS     = fxr_pkg::DIV_STEPS;
  localparam int CYCLES    = (INT_BITS + STEPS - 1) / STEPS;
  localparam int DIV_W     = CYCLES * STEPS;
  localparam int CNT_W     = (CYCLES > 1) ? $clog2(CYCLES) : 1;
  localparam int REM_W     = fxr_pkg::DIGIT_W;
  localparam int RADIX_W_L = fxr_pkg::RADIX_W;

  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  quo_next;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [RADIX_W_L-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  // A group of restoring steps: shift in the next dividend bit, subtract
  // the divisor when it fits and record the quotient bit.
  always_comb begin
    logic [REM_W:0]   r;
    logic [DIV_W-1:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int i = 0; i < STEPS; i++) begin
      r = {r[REM_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r[REM_W-1:0];
    quo_next = q;
  end

  // Sequencer of the shared divide step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= DIV_W'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo[INT_BITS-1:0];
  assign remainder = rem;

endmodule

`default_nettype wire

### sv/fixed_to_radix_n_digits.sv
// ---------------------------------------------------------------------------
// fixed_to_radix_n_digits: unsigned fixed-point number to base-N ASCII text
// Converts one Q(INT_BITS).(FRAC_BITS) number per request into characters.
// ---------------------------------------------------------------------------
// Each input request is an unsigned fixed-point number; the block answers
// with one ASCII character per output request: the integer digits most
// significant first (none when the integer part is zero), a '.', and then
// FRAC_DIGITS fraction digits, the last one flagged on m_tlast. The base
// comes from the 6-bit configuration register (reset 10); values below 2
// act as 2 and values above 36 act as 36. Integer digits come from a shared
// divider that resolves 4 quotient bits a cycle, one division per integer
// digit. Fraction digits take one multiply each and leave at one character
// per cycle while the output is not stalled. s_tready stays low from the
// acceptance of an item until its last fraction digit is loaded, so a new
// number is taken only after the previous one has been converted.
`default_nettype none

module fixed_to_radix_n_digits #(
  parameter int INT_BITS    = 24,
  parameter int FRAC_BITS   = 16,
  parameter int FRAC_DIGITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write: base of the conversion.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fxr_pkg::RADIX_W-1:0] cfg_data,   // [5:0] radix
  // Input stream.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [fxr_pkg::VALUE_W-1:0] s_tdata,    // [39:0] value
  // Output stream.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,    // [6:0] ascii_char, [7] zero
  output logic                             m_tlast
);

  localparam int NUM_W   = INT_BITS + FRAC_BITS;
  localparam int EXT_W   = (NUM_W > fxr_pkg::VALUE_W) ? NUM_W : fxr_pkg::VALUE_W;
  localparam int DEPTH_W = $clog2(INT_BITS + 1);
  localparam int IDX_W   = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;
  localparam int FC_W    = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int PROD_W  = FRAC_BITS + fxr_pkg::RADIX_W;

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    EMIT_INT,
    EMIT_POINT,
    EMIT_FRAC
  } state_t;

  state_t                         state;
  logic [fxr_pkg::RADIX_W-1:0]    radix;
  logic [fxr_pkg::RADIX_W-1:0]    base;
  logic [FRAC_BITS-1:0]           frac;
  logic [DEPTH_W-1:0]             depth;
  logic [DEPTH_W-1:0]             depth_dec;
  logic [FC_W-1:0]                fcnt;
  logic [fxr_pkg::DIGIT_W-1:0]    digit_stack [INT_BITS];

  logic [EXT_W-1:0]               value_ext;
  logic [INT_BITS-1:0]            ipart_in;
  logic [FRAC_BITS-1:0]           frac_in;
  logic                           accept;
  logic                           out_free;
  logic                           emit;
  logic [PROD_W-1:0]              prod;

  logic                           div_start;
  logic [INT_BITS-1:0]            div_dividend;
  logic                           div_done;
  logic [INT_BITS-1:0]            div_quotient;
  logic [fxr_pkg::DIGIT_W-1:0]    div_remainder;

  // Split the incoming number into integer and fraction parts.
  assign value_ext = EXT_W'(s_tdata);
  assign ipart_in  = value_ext[NUM_W-1:FRAC_BITS];
  assign frac_in   = value_ext[FRAC_BITS-1:0];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = out_free && ((state == EMIT_INT) || (state == EMIT_POINT) ||
                                  (state == EMIT_FRAC));
  assign depth_dec = depth - 1'b1;

  // One fraction step: the bits above the fraction are the next digit.
  assign prod = PROD_W'(frac) * PROD_W'(base);

  // Launch a division for the first digit and for every nonzero quotient.
  assign div_start    = (accept && (ipart_in != '0)) ||
                        ((state == DIVIDE) && div_done && (div_quotient != '0));
  assign div_dividend = (state == IDLE) ? ipart_in : div_quotient;

  fxr_div #(
    .INT_BITS (INT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((state == IDLE) ? fxr_pkg::eff_radix(radix) : base),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Base register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= fxr_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  // Integer digits, least significant first.
  always_ff @(posedge clk) begin
    if ((state == DIVIDE) && div_done) begin
      digit_stack[depth[IDX_W-1:0]] <= div_remainder;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      depth    <= '0;
      fcnt     <= '0;
    end else begin
      // Load a new character when the register is free, else drop it once taken.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            base  <= fxr_pkg::eff_radix(radix);
            frac  <= frac_in;
            depth <= '0;
            state <= (ipart_in != '0) ? DIVIDE : EMIT_POINT;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            depth <= depth + 1'b1;
            if (div_quotient == '0) begin
              state <= EMIT_INT;
            end
          end
        end
        EMIT_INT: begin
          if (out_free) begin
            m_tdata  <= {1'b0, fxr_pkg::digit_char(digit_stack[depth_dec[IDX_W-1:0]])};
            m_tlast  <= 1'b0;
            depth    <= depth_dec;
            if (depth == DEPTH_W'(1)) begin
              state <= EMIT_POINT;
            end
          end
        end
        EMIT_POINT: begin
          if (out_free) begin
            m_tdata  <= {1'b0, fxr_pkg::ASCII_POINT};
            m_tlast  <= 1'b0;
            fcnt     <= '0;
            state    <= EMIT_FRAC;
          end
        end
        EMIT_FRAC: begin
          if (out_free) begin
            m_tdata  <= {1'b0, fxr_pkg::digit_char(prod[FRAC_BITS +: fxr_pkg::DIGIT_W])};
            frac     <= prod[FRAC_BITS-1:0];
            fcnt     <= fcnt + 1'b1;
            if (fcnt == FC_W'(FRAC_DIGITS - 1)) begin
              m_tlast <= 1'b1;
              state   <= IDLE;
            end else begin
              m_tlast <= 1'b0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for fixed_to_radix_n_digits
// Feeds Q24.16 numbers under many bases, predicts the ASCII text each one
// must produce and compares every output request against that prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = fxr_pkg::VALUE_W;
  localparam int CHAR_W      = fxr_pkg::CHAR_W;
  localparam int RADIX_W     = fxr_pkg::RADIX_W;

  localparam int WHOLE_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_DIGITS = 8;
  localparam int DRAIN_WAIT  = 8;

  // One expected character of the output text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } glyph_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;     // [39:0] value
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;          // [6:0] ascii_char, [7] zero
  logic               m_tlast;

  // Bench copy of the base register and the queue of characters still owed.
  logic [RADIX_W-1:0] radix_shadow = fxr_pkg::RADIX_RESET;
  glyph_t             pending_text[$];

  int  errors = 0;
  int  values_sent = 0;
  int  chars_checked = 0;
  int  radix_writes = 0;
  bit  send_gaps = 1'b0;
  bit  sink_stalls = 1'b0;
  int  stall_left = 0;

  fixed_to_radix_n_digits i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time.
  initial begin
    #(12_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] glyph_of(input logic [5:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = fxr_pkg::ASCII_DIGIT_BASE + {1'b0, d};
    end else begin
      c = fxr_pkg::ASCII_LETTER_BASE + {1'b0, d};
    end
    return c;
  endfunction

  // Work out the full text for one number under the current base.
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [5:0]            base;
    logic [WHOLE_BITS-1:0] whole;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS+5:0]  prod;
    logic [5:0]            digits[WHOLE_BITS];
    int                    depth;
    if (radix_shadow < fxr_pkg::RADIX_MIN) begin
      base = fxr_pkg::RADIX_MIN;
    end else if (radix_shadow > fxr_pkg::RADIX_MAX) begin
      base = fxr_pkg::RADIX_MAX;
    end else begin
      base = radix_shadow;
    end
    whole = v[FRAC_BITS +: WHOLE_BITS];
    frac  = v[FRAC_BITS-1:0];
    depth = 0;
    // Integer digits come out least significant first.
    while (whole != 0) begin
      digits[depth] = 6'(whole % base);
      whole = whole / base;
      depth++;
    end
    for (int i = depth - 1; i >= 0; i--) begin
      pending_text.push_back('{glyph_of(digits[i]), 1'b0});
    end
    pending_text.push_back('{fxr_pkg::ASCII_POINT, 1'b0});
    // Fraction digits are the bits that spill above the fraction field.
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      prod = frac * base;
      frac = prod[FRAC_BITS-1:0];
      pending_text.push_back('{glyph_of(prod[FRAC_BITS +: 6]), k == FRAC_DIGITS - 1});
    end
  endfunction

  // Output side: random stall bursts while enabled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted character against the oldest one owed.
  always @(posedge clk) begin
    glyph_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_text.pop_front();
        chars_checked++;
        if (m_tdata !== {1'b0, want.ch}) begin
          $display("%0t: character mismatch: expected %h, actual %h",
                   $time, {1'b0, want.ch}, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last flag mismatch: expected %b, actual %b",
                   $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Send one number; valid stays high so the next request can follow at once.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (send_gaps && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    predict_text(v);
    values_sent++;
  endtask

  // Stop sending and wait until every owed character has arrived.
  task automatic drain_text();
    s_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the base register; only called while the converter is idle.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    radix_shadow  = r;
    radix_writes++;
  endtask

  // Random number with the integer and fraction parts shaped by kind.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [VALUE_W-1:0] v;
    lo = $urandom;
    hi = $urandom;
    v  = {hi[7:0], lo};
    case ($urandom_range(0, 5))
      0: v[VALUE_W-1:FRAC_BITS] = '0;
      1: v[VALUE_W-1:FRAC_BITS+8] = '0;
      2: v[FRAC_BITS-1:0] = '0;
      3: v[VALUE_W-1:FRAC_BITS] = '1;
      default: ;
    endcase
    return v;
  endfunction

  // Reset base of ten on the field extremes and two small values.
  task automatic test_default_base();
    send_value(40'h00_0000_0000);
    send_value(40'h00_0001_8000);
    send_value(40'h00_0000_8000);
    send_value(40'hFF_FFFF_FFFF);
    drain_text();
  endtask

  // Bases at and beyond both ends of the range, which clamp to 2 or 36.
  task automatic test_base_limits();
    logic [RADIX_W-1:0] edges[6];
    edges = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
    foreach (edges[i]) begin
      write_radix(edges[i]);
      send_value(40'hFF_FFFF_FFFF);
      send_value(40'h00_0000_0001);
      send_value(40'h80_0000_FFFF);
      drain_text();
    end
  endtask

  // Random numbers under random bases, with idling on both sides.
  task automatic test_random_text();
    for (int phase = 0; phase < 11; phase++) begin
      write_radix(RADIX_W'($urandom_range(0, 63)));
      send_gaps   = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      repeat (28) send_value(pick_value());
      drain_text();
    end
  endtask

  // Back-to-back requests with the output always ready.
  task automatic test_full_rate();
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    write_radix(RADIX_W'($urandom_range(2, 36)));
    repeat (40) send_value(pick_value());
    drain_text();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_base();
    test_base_limits();
    test_random_text();
    test_full_rate();
    $display("Converted %0d numbers under %0d base settings.", values_sent, radix_writes + 1);
    $display("Checked %0d output characters, %0d mismatches.", chars_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
